[rtl/mhf_pkg.sv]
// ----------------------------------------------------------------------------
// mhf_pkg
// Shared types, constants and the arctangent table of the heading filter.
// ----------------------------------------------------------------------------
package mhf_pkg;

  localparam int AtanEntries = 24;
  localparam int CordicStepsDefault = 16;
  localparam int AccW = 36;
  localparam logic signed [AccW-1:0] GainQ24 = 36'sd10188014;

  localparam logic [1:0] MODE_HEADING = 2'd0;
  localparam logic [1:0] MODE_CALIB   = 2'd1;
  localparam logic [1:0] MODE_FINISH  = 2'd2;
  localparam logic [1:0] MODE_LOAD    = 2'd3;

  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_ALPHA     = 2'd1;
  localparam logic [1:0] REG_STORED_X2 = 2'd2;
  localparam logic [1:0] REG_STORED_Y2 = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SAMPLE, ST_SAMPLE_WAIT, ST_SINCOS, ST_SINCOS_WAIT,
    ST_CUR, ST_CUR_WAIT, ST_EMA, ST_FINAL, ST_FINAL_WAIT, ST_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic rotate;
  } cordic_cmd_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] v;
    begin
      unique case (i)
        5'd0: v = 32'd536870912;  5'd1: v = 32'd316933406;
        5'd2: v = 32'd167458907;  5'd3: v = 32'd85004756;
        5'd4: v = 32'd42667331;   5'd5: v = 32'd21354465;
        5'd6: v = 32'd10680862;   5'd7: v = 32'd5340245;
        5'd8: v = 32'd2670163;    5'd9: v = 32'd1335087;
        5'd10: v = 32'd667544;    5'd11: v = 32'd333772;
        5'd12: v = 32'd166886;    5'd13: v = 32'd83443;
        5'd14: v = 32'd41721;     5'd15: v = 32'd20861;
        5'd16: v = 32'd10430;     5'd17: v = 32'd5215;
        5'd18: v = 32'd2608;      5'd19: v = 32'd1304;
        5'd20: v = 32'd652;       5'd21: v = 32'd326;
        5'd22: v = 32'd163;       5'd23: v = 32'd81;
        default: v = 32'd0;
      endcase
      return v;
    end
  endfunction

endpackage

[rtl/mhf_cordic.sv]
// ----------------------------------------------------------------------------
// mhf_cordic
// Shared iterative CORDIC: vectoring (atan2) or rotation (sin/cos), one
// micro-rotation per cycle.
// ----------------------------------------------------------------------------
module mhf_cordic import mhf_pkg::*; #(
  parameter int CORDIC_STEPS = CordicStepsDefault
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cordic_cmd_t            cmd,
  input  logic signed [17:0]     in_y,
  input  logic signed [17:0]     in_x,
  input  logic [15:0]            in_ang,
  output logic                   done,
  output logic [15:0]            ang,
  output logic signed [17:0]     sin_q,
  output logic signed [17:0]     cos_q
);

  localparam int IW = $clog2(CORDIC_STEPS + 1);

  logic signed [AccW-1:0] x, y, x_next, y_next, dx, dy;
  logic signed [33:0] z, z_next;
  logic [IW-1:0] step;
  logic busy, mode_rot, neg, zero_vec;
  logic signed [33:0] z0;
  logic signed [AccW-1:0] xs, ys, xr, yr;
  logic signed [33:0] zr;
  logic [33:0] zsum;

  always_comb begin
    dx = x >>> step;
    dy = y >>> step;
    x_next = x;
    y_next = y;
    z_next = z;
    if (mode_rot) begin
      if (!z[33]) begin
        x_next = x - dy; y_next = y + dx;
        z_next = z - $signed({2'b00, atan_turn(5'(step))});
      end else begin
        x_next = x + dy; y_next = y - dx;
        z_next = z + $signed({2'b00, atan_turn(5'(step))});
      end
    end else begin
      if (y > 0) begin
        x_next = x + dy; y_next = y - dx;
        z_next = z + $signed({2'b00, atan_turn(5'(step))});
      end else begin
        x_next = x - dy; y_next = y + dx;
        z_next = z - $signed({2'b00, atan_turn(5'(step))});
      end
    end
  end

  // initial rotation angle and inputs scaled by 256; the half-plane fold is applied at start
  always_comb begin
    z0 = $signed({{2{in_ang[15]}}, in_ang, 16'd0});
    xs = AccW'(in_x) <<< 8;
    ys = AccW'(in_y) <<< 8;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        step <= '0;
        mode_rot <= cmd.rotate;
        if (cmd.rotate) begin
          x <= GainQ24;
          y <= '0;
          neg <= 1'b0;
          zero_vec <= 1'b0;
          if (z0 > 34'sd1073741824) begin
            z <= z0 - 34'sd2147483648; neg <= 1'b1;
          end else if (z0 < -34'sd1073741824) begin
            z <= z0 + 34'sd2147483648; neg <= 1'b1;
          end else begin
            z <= z0;
          end
        end else begin
          zero_vec <= (in_x == 0) && (in_y == 0);
          neg <= 1'b0;
          if (in_x < 0) begin
            x <= -xs; y <= -ys; z <= 34'sd2147483648;
          end else begin
            x <= xs; y <= ys; z <= '0;
          end
        end
      end else if (busy) begin
        x <= x_next; y <= y_next; z <= z_next;
        if (step == IW'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        step <= step + 1'b1;
      end
    end
  end

  always_comb begin
    xr = (x + AccW'(128)) >>> 8;
    yr = (y + AccW'(128)) >>> 8;
    zr = z + 34'sd32768;
    zsum = zr;
    ang = zero_vec ? 16'd0 : zsum[31:16];
    cos_q = neg ? -xr[17:0] : xr[17:0];
    sin_q = neg ? -yr[17:0] : yr[17:0];
  end

`ifndef SYNTH
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("cordic done held");
  a_start_idle: assert property (@(posedge clk) disable iff (rst) cmd.start |=> busy)
    else $error("cordic did not start");
  a_done_end: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("cordic done while busy");
`endif

endmodule

[rtl/magnetometer_heading_filter_unit.sv]
// ----------------------------------------------------------------------------
// magnetometer_heading_filter_unit
// Hard-iron corrected, outlier gated, averaged compass heading.
// ----------------------------------------------------------------------------
// channel | signals                          | transfer
// in      | in_valid in_ready mode raw_*     | in_valid & in_ready
// out     | out_valid out_ready out_* ...    | out_valid & out_ready
// cfg     | cfg_we cfg_index cfg_data        | cfg_we
// A heading item runs up to four CORDIC passes of CORDIC_STEPS micro-rotations
// each on one shared unit; other modes go from ST_SAMPLE straight to ST_DONE.
// One item at a time; in_ready is low while an item is at work or its
// result waits. Reset is synchronous; the captured sample and result are not reset.
// ----------------------------------------------------------------------------
module magnetometer_heading_filter_unit import mhf_pkg::*; #(
  parameter int CORDIC_STEPS = CordicStepsDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         mode,
  input  logic signed [15:0] raw_x,
  input  logic signed [15:0] raw_y,
  input  logic signed [15:0] raw_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_x,
  output logic signed [15:0] out_y,
  output logic signed [15:0] out_z,
  output logic [15:0]        heading,
  output logic               heading_valid,
  output logic               sample_accepted,
  output logic signed [16:0] offset_x2_now,
  output logic signed [16:0] offset_y2_now,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [16:0]        cfg_data
);

  state_t state, state_next;
  cordic_cmd_t cmd;
  logic [15:0] outlier_threshold, filter_alpha;
  logic signed [16:0] stored_offset_x2, stored_offset_y2;
  logic signed [17:0] sine_avg, cosine_avg, sn, cs, cy_in, cx_in;
  logic filter_started, calib_seen;
  logic signed [16:0] offset_x2, offset_y2;
  logic signed [15:0] min_x, max_x, min_y, max_y;
  logic [1:0] mode_r;
  logic [15:0] samp_ang, cur_ang;
  logic c_done;
  logic [15:0] c_ang;
  logic signed [17:0] c_sin, c_cos;
  logic [15:0] diff, mag;
  logic signed [17:0] ema_old, ema_new;
  logic signed [18:0] ema_d;
  logic signed [35:0] ema_p;
  logic signed [17:0] ema_res;
  logic ema_sel;
  logic [31:0] hprod;

  mhf_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk, .rst, .cmd, .in_y(cy_in), .in_x(cx_in), .in_ang(samp_ang),
    .done(c_done), .ang(c_ang), .sin_q(c_sin), .cos_q(c_cos)
  );

  assign in_ready = (state == ST_IDLE);
  assign offset_x2_now = offset_x2;
  assign offset_y2_now = offset_y2;

  always_ff @(posedge clk) begin
    if (rst) begin
      outlier_threshold <= 16'd8192;
      filter_alpha <= 16'd19661;
      stored_offset_x2 <= '0;
      stored_offset_y2 <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_THRESHOLD: outlier_threshold <= cfg_data[15:0];
        REG_ALPHA:     filter_alpha <= cfg_data[15:0];
        REG_STORED_X2: stored_offset_x2 <= $signed(cfg_data);
        REG_STORED_Y2: stored_offset_y2 <= $signed(cfg_data);
      endcase
    end
  end

  always_comb begin
    diff = samp_ang - cur_ang;
    mag = diff[15] ? 16'(-diff) : diff;
    ema_old = ema_sel ? cosine_avg : sine_avg;
    ema_new = ema_sel ? cs : sn;
    ema_d = 19'(ema_new) - 19'(ema_old);
    ema_p = 36'(ema_d) * $signed({1'b0, filter_alpha}) + 36'sd32768;
    ema_res = ema_old + 18'(ema_p >>> 16);
    hprod = c_ang * 32'd36000 + 32'd32768;
    cy_in = (state == ST_SAMPLE) ? 18'(19'(2 * out_y) - 19'(offset_y2)) : sine_avg;
    cx_in = (state == ST_SAMPLE) ? 18'(19'(2 * out_x) - 19'(offset_x2)) : cosine_avg;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_SAMPLE;
      ST_SAMPLE: begin
        if (mode_r == MODE_HEADING) begin
          cmd.start = 1'b1; state_next = ST_SAMPLE_WAIT;
        end else state_next = ST_DONE;
      end
      ST_SAMPLE_WAIT: if (c_done) state_next = ST_SINCOS;
      ST_SINCOS: begin cmd.start = 1'b1; cmd.rotate = 1'b1; state_next = ST_SINCOS_WAIT; end
      ST_SINCOS_WAIT: if (c_done) state_next = filter_started ? ST_CUR : ST_FINAL;
      ST_CUR: begin cmd.start = 1'b1; state_next = ST_CUR_WAIT; end
      ST_CUR_WAIT: if (c_done) state_next = ST_EMA;
      ST_EMA: if (ema_sel || mag >= outlier_threshold) state_next = ST_FINAL;
      ST_FINAL: begin cmd.start = 1'b1; state_next = ST_FINAL_WAIT; end
      ST_FINAL_WAIT: if (c_done) state_next = ST_DONE;
      ST_DONE: if (out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  assign out_valid = (state == ST_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      sine_avg <= '0; cosine_avg <= '0; filter_started <= 1'b0;
      offset_x2 <= '0; offset_y2 <= '0;
      min_x <= 16'sh7fff; max_x <= 16'sh8000;
      min_y <= 16'sh7fff; max_y <= 16'sh8000;
      calib_seen <= 1'b0; ema_sel <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: if (in_valid) begin
          mode_r <= mode; out_x <= raw_x; out_y <= raw_y; out_z <= raw_z;
          heading <= '0; heading_valid <= 1'b0; sample_accepted <= 1'b0;
          ema_sel <= 1'b0;
        end
        ST_SAMPLE: unique case (mode_r)
          MODE_CALIB: begin
            if (out_x < min_x) min_x <= out_x;
            if (out_x > max_x) max_x <= out_x;
            if (out_y < min_y) min_y <= out_y;
            if (out_y > max_y) max_y <= out_y;
            calib_seen <= 1'b1;
          end
          MODE_FINISH: begin
            offset_x2 <= calib_seen ? 17'(max_x) + 17'(min_x) : '0;
            offset_y2 <= calib_seen ? 17'(max_y) + 17'(min_y) : '0;
            min_x <= 16'sh7fff; max_x <= 16'sh8000;
            min_y <= 16'sh7fff; max_y <= 16'sh8000;
            calib_seen <= 1'b0;
          end
          MODE_LOAD: begin
            offset_x2 <= stored_offset_x2; offset_y2 <= stored_offset_y2;
          end
          default: ;
        endcase
        ST_SAMPLE_WAIT: if (c_done) samp_ang <= c_ang;
        ST_SINCOS_WAIT: if (c_done) begin
          sn <= c_sin; cs <= c_cos;
          if (!filter_started) begin
            sine_avg <= c_sin; cosine_avg <= c_cos;
            filter_started <= 1'b1; sample_accepted <= 1'b1;
          end
        end
        ST_CUR_WAIT: if (c_done) cur_ang <= c_ang;
        ST_EMA: if (mag < outlier_threshold) begin
          if (ema_sel) cosine_avg <= ema_res;
          else sine_avg <= ema_res;
          ema_sel <= 1'b1;
          sample_accepted <= 1'b1;
        end
        ST_FINAL_WAIT: if (c_done) begin
          heading <= hprod[31:16]; heading_valid <= 1'b1;
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTH
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("accepted while busy");
  a_hv_mode: assert property (@(posedge clk) disable iff (rst)
    (out_valid && heading_valid) |-> (mode_r == MODE_HEADING))
    else $error("heading valid in wrong mode");
  a_acc_hv: assert property (@(posedge clk) disable iff (rst)
    (out_valid && sample_accepted) |-> heading_valid)
    else $error("accepted without heading");
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (heading < 16'd36000))
    else $error("heading out of range");
`endif

endmodule

[tb/tb_magnetometer_heading_filter_checker.sv]
// ----------------------------------------------------------------------------
// tb_magnetometer_heading_filter_checker
// Watches the sample and result channels and the register port, predicts
// each heading result with a bit-exact CORDIC and averaging model of the
// filter, and compares every result transfer field by field.
// ----------------------------------------------------------------------------
module tb_magnetometer_heading_filter_checker import mhf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         mode,
  input  logic signed [15:0] raw_x,
  input  logic signed [15:0] raw_y,
  input  logic signed [15:0] raw_z,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [15:0] out_x,
  input  logic signed [15:0] out_y,
  input  logic signed [15:0] out_z,
  input  logic [15:0]        heading,
  input  logic               heading_valid,
  input  logic               sample_accepted,
  input  logic signed [16:0] offset_x2_now,
  input  logic signed [16:0] offset_y2_now,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [16:0]        cfg_data,
  output int                 errors,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [15:0] x, y, z;
    logic [15:0]        hdg;
    logic               hv, acc;
    logic signed [16:0] ox, oy;
  } heading_result_t;

  heading_result_t result_q[$];

  logic [15:0] thresh, alpha;
  logic signed [16:0] st_x2, st_y2, off_x2, off_y2;
  longint sin_q, cos_q;
  logic started, seen;
  longint mn_x, mx_x, mn_y, mx_y;

  function automatic longint shr(longint v, int k);
    return v >>> k;
  endfunction

  function automatic logic [15:0] vec_angle(longint y, longint x);
    longint z, dx, dy;
    z = 0;
    if (x == 0 && y == 0) return 16'd0;
    x = x * 256;
    y = y * 256;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 64'sd2147483648;
    end
    for (int i = 0; i < CordicStepsDefault; i++) begin
      dx = shr(y, i);
      dy = shr(x, i);
      if (y > 0) begin
        x += dx; y -= dy; z += longint'(atan_turn(i[4:0]));
      end else begin
        x -= dx; y += dy; z -= longint'(atan_turn(i[4:0]));
      end
    end
    z += 32768;
    return z[31:16];
  endfunction

  task automatic unit_vector(input logic [15:0] ang, output longint s, output longint c);
    longint z, x, y, dx, dy;
    logic neg;
    z = longint'({ang, 16'h0});
    x = longint'(GainQ24);
    y = 0;
    neg = 1'b0;
    if (z >= 64'sd2147483648) z -= 64'sd4294967296;
    if (z > 64'sd1073741824) begin
      z -= 64'sd2147483648; neg = 1'b1;
    end else if (z < -64'sd1073741824) begin
      z += 64'sd2147483648; neg = 1'b1;
    end
    for (int i = 0; i < CordicStepsDefault; i++) begin
      dx = shr(y, i);
      dy = shr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(atan_turn(i[4:0]));
      end else begin
        x += dx; y -= dy; z += longint'(atan_turn(i[4:0]));
      end
    end
    x = shr(x + 128, 8);
    y = shr(y + 128, 8);
    if (neg) begin
      x = -x; y = -y;
    end
    c = x;
    s = y;
  endtask

  function automatic longint blend(longint prev, longint nw);
    return prev + shr((nw - prev) * longint'(alpha) + 32768, 16);
  endfunction

  task automatic clear_trackers();
    mn_x = 32767; mx_x = -32768; mn_y = 32767; mx_y = -32768;
    seen = 1'b0;
  endtask

  task automatic predict_step();
    heading_result_t r;
    longint cx, cy, s, c, mag;
    logic [15:0] ang, cur, h, d;
    r.x = raw_x; r.y = raw_y; r.z = raw_z;
    r.hdg = '0; r.hv = 1'b0; r.acc = 1'b0;
    case (mode)
      MODE_HEADING: begin
        cx = 2 * longint'(raw_x) - longint'(off_x2);
        cy = 2 * longint'(raw_y) - longint'(off_y2);
        ang = vec_angle(cy, cx);
        unit_vector(ang, s, c);
        if (!started) begin
          sin_q = s; cos_q = c; started = 1'b1; r.acc = 1'b1;
        end else begin
          cur = vec_angle(sin_q, cos_q);
          d = ang - cur;
          mag = longint'($signed(d));
          if (mag < 0) mag = -mag;
          if (mag < longint'(thresh)) begin
            sin_q = blend(sin_q, s);
            cos_q = blend(cos_q, c);
            r.acc = 1'b1;
          end
        end
        h = vec_angle(sin_q, cos_q);
        r.hdg = 16'((longint'(h) * 36000 + 32768) >> 16);
        r.hv = 1'b1;
      end
      MODE_CALIB: begin
        if (raw_x < mn_x) mn_x = raw_x;
        if (raw_x > mx_x) mx_x = raw_x;
        if (raw_y < mn_y) mn_y = raw_y;
        if (raw_y > mx_y) mx_y = raw_y;
        seen = 1'b1;
      end
      MODE_FINISH: begin
        if (seen) begin
          off_x2 = 17'(mx_x + mn_x);
          off_y2 = 17'(mx_y + mn_y);
        end else begin
          off_x2 = '0; off_y2 = '0;
        end
        clear_trackers();
      end
      default: begin
        off_x2 = st_x2; off_y2 = st_y2;
      end
    endcase
    r.ox = off_x2; r.oy = off_y2;
    result_q.push_back(r);
  endtask

  task automatic compare_result();
    heading_result_t e;
    if (result_q.size() == 0) begin
      $display("%0t: unexpected result transfer x=%0d", $realtime, out_x);
      errors++;
      return;
    end
    e = result_q.pop_front();
    if (out_x !== e.x || out_y !== e.y || out_z !== e.z || heading !== e.hdg ||
        heading_valid !== e.hv || sample_accepted !== e.acc ||
        offset_x2_now !== e.ox || offset_y2_now !== e.oy) begin
      $display("%0t: mismatch expected x=%0d y=%0d z=%0d hdg=%0d hv=%0b acc=%0b ox=%0d oy=%0d",
               $realtime, e.x, e.y, e.z, e.hdg, e.hv, e.acc, e.ox, e.oy);
      $display("%0t:          actual   x=%0d y=%0d z=%0d hdg=%0d hv=%0b acc=%0b ox=%0d oy=%0d",
               $realtime, out_x, out_y, out_z, heading, heading_valid, sample_accepted,
               offset_x2_now, offset_y2_now);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      thresh = 16'd8192; alpha = 16'd19661;
      st_x2 = '0; st_y2 = '0; off_x2 = '0; off_y2 = '0;
      sin_q = 0; cos_q = 0; started = 1'b0;
      clear_trackers();
      result_q.delete();
    end else begin
      if (out_valid && out_ready) compare_result();
      if (cfg_we) begin
        case (cfg_index)
          REG_THRESHOLD: thresh = cfg_data[15:0];
          REG_ALPHA:     alpha = cfg_data[15:0];
          REG_STORED_X2: st_x2 = cfg_data;
          default:       st_y2 = cfg_data;
        endcase
      end
      if (in_valid && in_ready) predict_step();
    end
    pending <= result_q.size();
  end

  initial errors = 0;
endmodule

[tb/tb_magnetometer_heading_filter_unit.sv]
// ----------------------------------------------------------------------------
// tb_magnetometer_heading_filter_unit
// Drives directed and random heading, calibration, finish and load items
// through several register settings with random idling on both sides and
// one long result hold-off; the checker module does all comparison.
// ----------------------------------------------------------------------------
module tb_magnetometer_heading_filter_unit import mhf_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0, rst = 1'b1;
  logic in_valid = 1'b0, in_ready, out_valid, out_ready = 1'b0;
  logic [1:0] mode = '0;
  logic signed [15:0] raw_x = '0, raw_y = '0, raw_z = '0;
  logic signed [15:0] out_x, out_y, out_z;
  logic [15:0] heading;
  logic heading_valid, sample_accepted;
  logic signed [16:0] offset_x2_now, offset_y2_now;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [16:0] cfg_data = '0;
  int errors, pending;
  int stall = 0;
  bit quiet = 1'b0, hold_off = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  magnetometer_heading_filter_unit dut (.*);
  tb_magnetometer_heading_filter_checker chk (.*);

  task automatic send(input logic [1:0] m, input logic [15:0] x, input logic [15:0] y,
                      input logic [15:0] z);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 16);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1; mode <= m; raw_x <= x; raw_y <= y; raw_z <= z;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [16:0] val);
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] rnd_axis();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'($signed($urandom_range(0, 400)) - 200);
      default: return 16'($urandom);
    endcase
  endfunction

  // result side: random stall bursts, one long hold-off
  always @(posedge clk) begin
    if (rst || hold_off) out_ready <= 1'b0;
    else if (quiet) out_ready <= 1'b1;
    else if (stall > 0) begin
      stall <= stall - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      stall <= $urandom_range(0, 15);
      out_ready <= 1'b0;
    end else out_ready <= 1'b1;
  end

  initial begin
    repeat (200) @(posedge clk);
    while (rst) @(posedge clk);
    repeat (300) @(posedge clk);
    hold_off <= 1'b1;
    repeat (600) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    logic [15:0] ax, ay;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: zero vector, extremes, calibration, finish with nothing seen
    send(MODE_HEADING, 16'h0000, 16'h0000, 16'h1234);
    send(MODE_HEADING, 16'h7fff, 16'h0000, 16'h8000);
    send(MODE_HEADING, 16'h8000, 16'h0000, 16'h7fff);
    send(MODE_HEADING, 16'h0000, 16'h7fff, 16'hffff);
    send(MODE_HEADING, 16'h0000, 16'h8000, 16'h0000);
    send(MODE_HEADING, 16'h8000, 16'h8000, 16'h5555);
    send(MODE_FINISH, 16'h0000, 16'h0000, 16'h0000);
    send(MODE_CALIB, 16'h7fff, 16'h8000, 16'haaaa);
    send(MODE_CALIB, 16'h8000, 16'h7fff, 16'h5555);
    send(MODE_FINISH, 16'hffff, 16'hffff, 16'hffff);
    send(MODE_HEADING, 16'h0100, 16'h0020, 16'h0000);
    send(MODE_LOAD, 16'h0001, 16'h0002, 16'h0003);
    send(MODE_HEADING, 16'hff00, 16'h0000, 16'h0000);
    write_reg(REG_THRESHOLD, 17'd32768);
    write_reg(REG_STORED_X2, 17'h10000);
    write_reg(REG_STORED_Y2, 17'h0fffe);
    send(MODE_LOAD, 16'h0000, 16'h0000, 16'h0000);
    send(MODE_HEADING, 16'h0000, 16'h0000, 16'h0000);
    send(MODE_HEADING, 16'h8000, 16'h8000, 16'h0000);
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        1: begin write_reg(REG_ALPHA, 17'd65535); write_reg(REG_THRESHOLD, 17'd0); end
        2: begin write_reg(REG_ALPHA, 17'd0); write_reg(REG_THRESHOLD, 17'd1); end
        3: begin
          write_reg(REG_ALPHA, 17'($urandom)); write_reg(REG_THRESHOLD, 17'($urandom_range(0, 32768)));
        end
        4: begin
          write_reg(REG_STORED_X2, 17'($urandom_range(0, 131071) & 17'h1fffe));
          write_reg(REG_STORED_Y2, 17'($urandom));
        end
        5: begin write_reg(REG_ALPHA, 17'd19661); write_reg(REG_THRESHOLD, 17'd8192); end
        7: quiet = 1'b1;
        default: ;
      endcase
      for (int n = 0; n < 125; n++) begin
        case ($urandom_range(0, 19))
          0, 1, 2: send(MODE_CALIB, rnd_axis(), rnd_axis(), 16'($urandom));
          3: send(MODE_FINISH, 16'($urandom), 16'($urandom), 16'($urandom));
          4: send(MODE_LOAD, 16'($urandom), 16'($urandom), 16'($urandom));
          default: begin
            // mostly small random fields, sometimes edge-case axis values
            ax = 16'($signed($urandom_range(0, 2000)) - 1000);
            ay = 16'($signed($urandom_range(0, 2000)) - 1000);
            if ($urandom_range(0, 3) == 0) begin ax = rnd_axis(); ay = rnd_axis(); end
            send(MODE_HEADING, ax, ay, 16'($urandom));
          end
        endcase
      end
    end
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) $display("tb_magnetometer_heading_filter_unit: PASS");
    else $display("tb_magnetometer_heading_filter_unit: FAIL");
    $finish;
  end

  initial begin
    #2ms;
    $display("tb_magnetometer_heading_filter_unit: FAIL");
    $finish;
  end
endmodule

[magnetometer_heading_filter_unit.f]
rtl/mhf_pkg.sv
rtl/mhf_cordic.sv
rtl/magnetometer_heading_filter_unit.sv
tb/tb_magnetometer_heading_filter_checker.sv
tb/tb_magnetometer_heading_filter_unit.sv
